FILE: sv/bwp_pkg.sv
// ----------------------------------------------------------------------------
// bwp_pkg
// Shared constants, types and helpers for the blockwise three-way partition.
// ----------------------------------------------------------------------------
`default_nettype none

package bwp_pkg;

    localparam int MAX_ELEMS  = 1024;
    localparam int MAX_BLOCKS = 16;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int BLK_W      = 5;
    localparam int TIDX_W     = $clog2(MAX_BLOCKS);
    localparam int SUM_W      = 48;
    localparam int STEP_W     = $clog2(SUM_W + 1);
    localparam int PIVOT_SPAN = 100;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [BLK_W-1:0] BLOCKS_RESET = BLK_W'(4);

    typedef struct packed {
        logic idle;
        logic done;
        logic rd_valid;
    } t_core_stat;

    typedef struct packed {
        logic [CNT_W-1:0]  last_smaller;
        logic [CNT_W-1:0]  first_larger;
        logic [DATA_W-1:0] pivot;
        logic              status;
    } t_bounds;

    // Zero acts as one block, anything above the maximum as the maximum.
    function automatic logic [BLK_W-1:0] clamp_blocks(input logic [BLK_W-1:0] b);
        logic [BLK_W-1:0] r;
        r = b;
        if (b == '0) begin
            r = BLK_W'(1);
        end else if (b > BLK_W'(MAX_BLOCKS)) begin
            r = BLK_W'(MAX_BLOCKS);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bwp_div.sv
// ----------------------------------------------------------------------------
// bwp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bwp_div
    import bwp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [CNT_W-1:0]  i_divisor,
    output logic                   o_busy,
    output logic [SUM_W-1:0]       o_quot
);

    logic [SUM_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic [CNT_W:0]    trial;
    logic              qbit;

    assign trial = {r_rem, r_quot[SUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(SUM_W);
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= qbit ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
            r_quot <= {r_quot[SUM_W-2:0], qbit};
            r_cnt  <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: sv/bwp_core.sv
// ----------------------------------------------------------------------------
// bwp_core
// Element and scratch memories with the load, read and partition sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bwp_core
    import bwp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic              i_req_type,
    input  wire logic [DATA_W-1:0] i_elem_value,
    input  wire logic              i_is_last,
    input  wire logic [ADDR_W-1:0] i_read_index,
    input  wire logic [BLK_W-1:0]  i_block_count,
    output t_core_stat             o_stat,
    output logic [DATA_W-1:0]      o_rd_data,
    output t_bounds                o_bounds
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_DIVP   = 4'd3;
    localparam logic [3:0] S_DIVP_W = 4'd4;
    localparam logic [3:0] S_DIVS_W = 4'd5;
    localparam logic [3:0] S_BINIT  = 4'd6;
    localparam logic [3:0] S_BRUN   = 4'd7;
    localparam logic [3:0] S_CINIT  = 4'd8;
    localparam logic [3:0] S_CRUN   = 4'd9;

    localparam logic [1:0] SEG_LT = 2'd0;
    localparam logic [1:0] SEG_EQ = 2'd1;
    localparam logic [1:0] SEG_GT = 2'd2;

    logic [DATA_W-1:0] elem_mem [MAX_ELEMS];
    logic [DATA_W-1:0] scr_mem  [MAX_ELEMS];

    logic [3:0]        r_state;
    logic              r_done;
    logic [CNT_W-1:0]  r_count;
    logic              r_rd_valid;
    logic              r_rd_ok;
    logic [DATA_W-1:0] r_elem_q;
    logic [DATA_W-1:0] r_scr_q;
    logic [BLK_W-1:0]  r_blocks;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_i;
    logic [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0] r_pivot;
    logic [CNT_W-1:0]  r_size;
    logic [BLK_W-1:0]  r_t;
    logic [CNT_W-1:0]  r_start;
    logic [CNT_W-1:0]  r_end;
    logic [CNT_W-1:0]  r_s;
    logic [CNT_W-1:0]  r_e;
    logic [CNT_W-1:0]  r_l;
    logic [CNT_W-1:0]  r_ts;
    logic [CNT_W-1:0]  r_te;
    logic [CNT_W-1:0]  r_pos_s;
    logic [CNT_W-1:0]  r_pos_e;
    logic [CNT_W-1:0]  r_pos_l;
    logic              r_pv;
    logic [1:0]        r_pseg;
    logic [CNT_W-1:0]  r_sc [MAX_BLOCKS];
    logic [CNT_W-1:0]  r_ec [MAX_BLOCKS];
    logic [CNT_W-1:0]  r_lc [MAX_BLOCKS];
    t_bounds           r_bnd;

    // memory port controls
    logic              elem_re;
    logic [ADDR_W-1:0] elem_raddr;
    logic              elem_we;
    logic [ADDR_W-1:0] elem_waddr;
    logic [DATA_W-1:0] elem_wdata;
    logic              scr_re;
    logic              scr_we;
    logic [ADDR_W-1:0] scr_waddr;

    // helpers
    logic [BLK_W-1:0]  blk_cl;
    logic [CNT_W-1:0]  span;
    logic [CNT_W-1:0]  cnt_eff;
    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic              div_start;
    logic [SUM_W-1:0]  div_dvd;
    logic [CNT_W-1:0]  div_dvs;
    logic              div_busy;
    logic [SUM_W-1:0]  div_quot;
    logic [DATA_W-1:0] q_lo;
    logic              issue;
    logic [CNT_W-1:0]  blen;
    logic [CNT_W-1:0]  ts_new;
    logic [CNT_W-1:0]  te_new;
    logic [TIDX_W-1:0] tix;
    logic              last_blk;
    logic              v_lt;
    logic              v_gt;

    assign blk_cl   = clamp_blocks(i_block_count);
    assign span     = CNT_W'(PIVOT_SPAN * int'(blk_cl));
    assign cnt_eff  = r_done ? '0 : r_count;
    assign neg      = r_sum[SUM_W-1];
    assign mag      = neg ? (~r_sum + SUM_W'(1)) : r_sum;
    assign q_lo     = div_quot[DATA_W-1:0];
    assign blen     = r_s + r_e + r_l;
    assign ts_new   = r_ts + r_s;
    assign te_new   = r_te + r_e;
    assign tix      = r_t[TIDX_W-1:0];
    assign last_blk = (r_t == r_blocks - BLK_W'(1));
    assign v_lt     = $signed(r_elem_q) < $signed(r_pivot);
    assign v_gt     = $signed(r_elem_q) > $signed(r_pivot);

    // memory port selection
    always_comb begin
        elem_re    = 1'b0;
        elem_raddr = r_i[ADDR_W-1:0];
        elem_we    = 1'b0;
        elem_waddr = cnt_eff[ADDR_W-1:0];
        elem_wdata = i_elem_value;
        scr_re     = 1'b0;
        scr_we     = 1'b0;
        scr_waddr  = ADDR_W'(r_start + r_s);
        issue      = 1'b0;
        div_start  = 1'b0;
        div_dvd    = mag;
        div_dvs    = r_len;
        unique case (r_state)
            S_IDLE: begin
                if (i_acc && i_req_type == REQ_LOAD) begin
                    elem_we = (cnt_eff < CNT_W'(MAX_ELEMS));
                end
                if (i_acc && i_req_type == REQ_READ && r_done) begin
                    elem_re    = 1'b1;
                    elem_raddr = i_read_index;
                end
            end
            S_SUM, S_BRUN: begin
                issue   = (r_i < ((r_state == S_SUM) ? r_len : r_end));
                elem_re = issue;
                if (r_state == S_BRUN && r_pv) begin
                    scr_we = v_lt || v_gt;
                    if (v_lt) begin
                        scr_waddr = ADDR_W'(r_start + r_s);
                    end else begin
                        scr_waddr = ADDR_W'(r_end - CNT_W'(1) - r_l);
                    end
                end
            end
            S_DIVP: begin
                div_start = 1'b1;
            end
            S_DIVP_W: begin
                div_start = !div_busy;
                div_dvd   = SUM_W'(r_count);
                div_dvs   = CNT_W'(r_blocks);
            end
            S_CRUN: begin
                issue  = (r_i < blen);
                scr_re = issue;
                if (r_pv) begin
                    elem_we = 1'b1;
                    unique case (r_pseg)
                        SEG_LT: elem_waddr = r_pos_s[ADDR_W-1:0];
                        SEG_EQ: elem_waddr = r_pos_e[ADDR_W-1:0];
                        default: elem_waddr = r_pos_l[ADDR_W-1:0];
                    endcase
                    elem_wdata = (r_pseg == SEG_EQ) ? r_pivot : r_scr_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            r_elem_q <= elem_mem[elem_raddr];
        end
        if (scr_we) begin
            scr_mem[scr_waddr] <= r_elem_q;
        end
        if (scr_re) begin
            r_scr_q <= scr_mem[ADDR_W'(r_start + r_i)];
        end
    end

    bwp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            r_pv       <= 1'b0;
            r_bnd      <= '0;
        end else begin
            r_rd_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_acc && i_req_type == REQ_LOAD) begin
                        r_done  <= 1'b0;
                        r_count <= (cnt_eff < CNT_W'(MAX_ELEMS)) ? cnt_eff + CNT_W'(1)
                                                                  : cnt_eff;
                        if (i_is_last) begin
                            r_state <= S_CHECK;
                        end
                    end
                    if (i_acc && i_req_type == REQ_READ && r_done) begin
                        r_rd_valid <= 1'b1;
                        r_rd_ok    <= ({1'b0, i_read_index} < r_count);
                    end
                end
                S_CHECK: begin
                    r_blocks <= blk_cl;
                    if (r_count < CNT_W'(blk_cl)) begin
                        r_done  <= 1'b1;
                        r_bnd   <= '{last_smaller: '1, first_larger: r_count,
                                     pivot: '0, status: 1'b1};
                        r_state <= S_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                        r_len   <= (r_count < span) ? r_count : span;
                        r_i     <= '0;
                        r_sum   <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_i <= r_i + CNT_W'(1);
                    end
                    if (r_pv) begin
                        r_sum <= r_sum + {{(SUM_W-DATA_W){r_elem_q[DATA_W-1]}}, r_elem_q};
                    end
                    if (!issue && !r_pv) begin
                        r_state <= S_DIVP;
                    end
                end
                S_DIVP: begin
                    r_state <= S_DIVP_W;
                end
                S_DIVP_W: begin
                    if (!div_busy) begin
                        r_pivot <= neg ? (~q_lo + DATA_W'(1)) : q_lo;
                        r_state <= S_DIVS_W;
                    end
                end
                S_DIVS_W: begin
                    if (!div_busy) begin
                        r_size  <= div_quot[CNT_W-1:0];
                        r_t     <= '0;
                        r_start <= '0;
                        r_ts    <= '0;
                        r_te    <= '0;
                        r_state <= S_BINIT;
                    end
                end
                S_BINIT: begin
                    r_end   <= last_blk ? r_count : r_start + r_size;
                    r_i     <= r_start;
                    r_s     <= '0;
                    r_e     <= '0;
                    r_l     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_BRUN;
                end
                S_BRUN: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_i <= r_i + CNT_W'(1);
                    end
                    if (r_pv) begin
                        priority if (v_lt) begin
                            r_s <= r_s + CNT_W'(1);
                        end else if (v_gt) begin
                            r_l <= r_l + CNT_W'(1);
                        end else begin
                            r_e <= r_e + CNT_W'(1);
                        end
                    end
                    if (!issue && !r_pv) begin
                        r_sc[tix] <= r_s;
                        r_ec[tix] <= r_e;
                        r_lc[tix] <= r_l;
                        r_ts      <= ts_new;
                        r_te      <= te_new;
                        if (last_blk) begin
                            r_t     <= '0;
                            r_start <= '0;
                            r_pos_s <= '0;
                            r_pos_e <= ts_new;
                            r_pos_l <= ts_new + te_new;
                            r_state <= S_CINIT;
                        end else begin
                            r_t     <= r_t + BLK_W'(1);
                            r_start <= r_start + r_size;
                            r_state <= S_BINIT;
                        end
                    end
                end
                S_CINIT: begin
                    r_s     <= r_sc[tix];
                    r_e     <= r_ec[tix];
                    r_l     <= r_lc[tix];
                    r_i     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_CRUN;
                end
                S_CRUN: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_i <= r_i + CNT_W'(1);
                        if (r_i < r_s) begin
                            r_pseg <= SEG_LT;
                        end else if (r_i < r_s + r_e) begin
                            r_pseg <= SEG_EQ;
                        end else begin
                            r_pseg <= SEG_GT;
                        end
                    end
                    if (r_pv) begin
                        unique case (r_pseg)
                            SEG_LT: r_pos_s <= r_pos_s + CNT_W'(1);
                            SEG_EQ: r_pos_e <= r_pos_e + CNT_W'(1);
                            default: r_pos_l <= r_pos_l + CNT_W'(1);
                        endcase
                    end
                    if (!issue && !r_pv) begin
                        if (last_blk) begin
                            r_bnd   <= '{last_smaller: r_ts - CNT_W'(1),
                                         first_larger: r_ts + r_te,
                                         pivot: r_pivot, status: 1'b0};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_t     <= r_t + BLK_W'(1);
                            r_start <= r_start + r_size;
                            r_state <= S_CINIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = r_done;
    assign o_stat.rd_valid = r_rd_valid;
    assign o_rd_data       = r_rd_ok ? r_elem_q : '0;
    assign o_bounds        = r_bnd;

endmodule

`default_nettype wire

FILE: sv/blockwise_three_way_partition.sv
// ----------------------------------------------------------------------------
// blockwise_three_way_partition
// Loads signed elements, partitions them blockwise about the mean of the
// first 100*block_count of them and serves reads of the partitioned array.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+-----------------------------------
//  in       | i_in_valid / o_in_ready      | req_type, elem_value, is_last,
//           |                              | read_index
//  out      | o_out_valid / i_out_ready    | out_value, last_smaller_index,
//           |                              | first_larger_index, pivot_value,
//           |                              | status
//  config   | i_cfg_we (no wait)           | i_cfg_data = block_count
//
//  A read passes through an element memory read, then the output register;
//  reads while no partition has finished are taken and dropped. The load
//  marked last starts the partition, which holds off input until done;
//  with at least as many elements as blocks it runs a mean sum pass, two
//  serial divisions, a split pass into the scratch memory and a compaction
//  pass back, each limited by one memory port. Reset is synchronous and
//  active low and clears control state only; the memories hold garbage
//  until written. A stalled result blocks the input.
// ----------------------------------------------------------------------------
`default_nettype none

module blockwise_three_way_partition
    import bwp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [DATA_W-1:0] i_elem_value,
    input  wire logic              i_is_last,
    input  wire logic [ADDR_W-1:0] i_read_index,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_out_value,
    output logic [CNT_W-1:0]       o_last_smaller_index,
    output logic [CNT_W-1:0]       o_first_larger_index,
    output logic [DATA_W-1:0]      o_pivot_value,
    output logic                   o_status,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [BLK_W-1:0]  i_cfg_data
);

    logic [BLK_W-1:0]  r_block_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_bounds           r_out_bnd;

    t_core_stat        stat;
    logic [DATA_W-1:0] rd_data;
    t_bounds           bounds;
    logic              in_acc;

    // Take a transaction only when the sequencer is idle, no read is in the
    // memory stage and the output register will be free to hold its result.
    assign o_in_ready = stat.idle && !stat.rd_valid && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // block count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCKS_RESET;
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_data;
        end
    end

    bwp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (in_acc),
        .i_req_type    (i_req_type),
        .i_elem_value  (i_elem_value),
        .i_is_last     (i_is_last),
        .i_read_index  (i_read_index),
        .i_block_count (r_block_count),
        .o_stat        (stat),
        .o_rd_data     (rd_data),
        .o_bounds      (bounds)
    );

    // Output register: load on returning read data, drop on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.rd_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.rd_valid) begin
            r_out_value <= rd_data;
            r_out_bnd   <= bounds;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_value          = r_out_value;
    assign o_last_smaller_index = r_out_bnd.last_smaller;
    assign o_first_larger_index = r_out_bnd.first_larger;
    assign o_pivot_value        = r_out_bnd.pivot;
    assign o_status             = r_out_bnd.status;

endmodule

`default_nettype wire

FILE: sv/bwp_checker.sv
// ----------------------------------------------------------------------------
// bwp_checker
// Port-level checks on the partition block's result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module bwp_checker
    import bwp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [CNT_W-1:0]  o_last_smaller_index,
    input wire logic [CNT_W-1:0]  o_first_larger_index,
    input wire logic [DATA_W-1:0] o_pivot_value,
    input wire logic              o_status
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_pivot_value == '0 && o_last_smaller_index == '1)
        else $error("unpartitioned status with partition fields");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_last_smaller_index} + (CNT_W+1)'(1))
                        <= {1'b0, o_first_larger_index}
                        || o_last_smaller_index == '1)
        else $error("smaller region overlaps larger region");

endmodule

bind blockwise_three_way_partition bwp_checker u_bwp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_last_smaller_index (o_last_smaller_index),
    .o_first_larger_index (o_first_larger_index),
    .o_pivot_value        (o_pivot_value),
    .o_status             (o_status)
);

`default_nettype wire
